/* rtl/core/sap_pkg.sv */
// Shared types, constants and helpers for the skyline atlas packer.
// No dependencies; every other file but sap_ram refers to this package.
`default_nettype none
package sap_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int MAX_COLUMNS = 1024;
    localparam int MIN_COLUMNS = 8;

    localparam int ITEM_AW  = $clog2(MAX_ITEMS);
    localparam int ITEM_CW  = ITEM_AW + 1;
    localparam int COL_AW   = $clog2(MAX_COLUMNS);
    localparam int COL_CW   = COL_AW + 1;
    localparam int CELL_W   = 16;                    // (15-bit pixels >> m) + 1
    localparam int HEIGHT_W = CELL_W + ITEM_CW - 1;  // sum of all cell heights
    localparam int MIP_MAX  = 4;
    localparam int POS_MAX  = 32767;
    localparam int AH_MAX   = 32768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BASE,
        ST_CLEAR,
        ST_LOAD,
        ST_LOADW,
        ST_FWD,
        ST_BWD,
        ST_WIN,
        ST_PUT,
        ST_CHECK,
        ST_AH,
        ST_ORD,
        ST_OCAP,
        ST_OWAIT
    } sap_state_t;

    typedef struct packed {
        logic [14:0] tex_width;
        logic [14:0] tex_height;
        logic        last_item;
    } sap_in_t;

    typedef struct packed {
        logic [5:0]  item_index;
        logic [14:0] pos_x;
        logic [14:0] pos_y;
        logic [14:0] atlas_width;
        logic [15:0] atlas_hgt;
        logic        overflow;
        logic        last_result;
    } sap_out_t;

    typedef struct packed {
        sap_state_t phase;
        sap_state_t next;
        logic       restart;
        logic       in_fire;
        logic       out_fire;
    } sap_cmd_t;

    typedef struct packed {
        logic base_done;
        logic sweep_done;
        logic items_done;
        logic repack;
        logic ah_done;
        logic out_last;
    } sap_status_t;

    function automatic logic [HEIGHT_W-1:0] hmax(input logic [HEIGHT_W-1:0] a,
                                                 input logic [HEIGHT_W-1:0] b);
        hmax = (a > b) ? a : b;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/sap_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/sap_ctrl.sv */
// Sequencer of the skyline atlas packer: collect, pack passes, result output.
// Depends on sap_pkg.
`default_nettype none
module sap_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_last,
    input  wire logic                out_ready,
    input  wire sap_pkg::sap_status_t status,
    output logic                     in_ready,
    output logic                     out_valid,
    output sap_pkg::sap_cmd_t        cmd
);

    sap_pkg::sap_state_t state_reg;
    sap_pkg::sap_state_t state_next;
    logic                in_fire;
    logic                out_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sap_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        in_ready   = (state_reg == sap_pkg::ST_IDLE);
        out_valid  = (state_reg == sap_pkg::ST_OWAIT);
        in_fire    = in_valid && in_ready;
        out_fire   = out_valid && out_ready;
        state_next = state_reg;
        case (state_reg)
            sap_pkg::ST_IDLE:
            begin
                if (in_fire && in_last)
                begin
                    state_next = sap_pkg::ST_BASE;
                end
            end
            sap_pkg::ST_BASE:
            begin
                if (status.base_done)
                begin
                    state_next = sap_pkg::ST_CLEAR;
                end
            end
            sap_pkg::ST_CLEAR:
            begin
                if (status.sweep_done)
                begin
                    state_next = sap_pkg::ST_LOAD;
                end
            end
            sap_pkg::ST_LOAD:  state_next = sap_pkg::ST_LOADW;
            sap_pkg::ST_LOADW: state_next = sap_pkg::ST_FWD;
            sap_pkg::ST_FWD:
            begin
                if (status.sweep_done)
                begin
                    state_next = sap_pkg::ST_BWD;
                end
            end
            sap_pkg::ST_BWD:
            begin
                if (status.sweep_done)
                begin
                    state_next = sap_pkg::ST_WIN;
                end
            end
            sap_pkg::ST_WIN:
            begin
                if (status.sweep_done)
                begin
                    state_next = sap_pkg::ST_PUT;
                end
            end
            sap_pkg::ST_PUT:
            begin
                if (status.sweep_done)
                begin
                    state_next = status.items_done ? sap_pkg::ST_CHECK : sap_pkg::ST_LOAD;
                end
            end
            sap_pkg::ST_CHECK:
            begin
                state_next = status.repack ? sap_pkg::ST_CLEAR : sap_pkg::ST_AH;
            end
            sap_pkg::ST_AH:
            begin
                if (status.ah_done)
                begin
                    state_next = sap_pkg::ST_ORD;
                end
            end
            sap_pkg::ST_ORD:  state_next = sap_pkg::ST_OCAP;
            sap_pkg::ST_OCAP: state_next = sap_pkg::ST_OWAIT;
            sap_pkg::ST_OWAIT:
            begin
                if (out_fire)
                begin
                    state_next = status.out_last ? sap_pkg::ST_IDLE : sap_pkg::ST_ORD;
                end
            end
            default: state_next = sap_pkg::ST_IDLE;
        endcase
        cmd.phase    = state_reg;
        cmd.next     = state_next;
        cmd.restart  = (state_next != state_reg);
        cmd.in_fire  = in_fire;
        cmd.out_fire = out_fire;
    end

endmodule
`default_nettype wire

/* rtl/core/sap_datapath.sv */
// Datapath: item and position stores, skyline with prefix/suffix max sweeps,
// window search, atlas size and result formatting. Depends on sap_pkg, sap_ram.
`default_nettype none
module sap_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_wdata,
    input  wire sap_pkg::sap_in_t    in_data,
    input  wire sap_pkg::sap_cmd_t   cmd,
    output sap_pkg::sap_status_t     status,
    output sap_pkg::sap_out_t        out_data
);

    localparam int H   = sap_pkg::HEIGHT_W;
    localparam int CW  = sap_pkg::COL_CW;
    localparam int AW  = sap_pkg::COL_AW;
    localparam int IAW = sap_pkg::ITEM_AW;
    localparam int ICW = sap_pkg::ITEM_CW;
    localparam int CL  = sap_pkg::CELL_W;
    localparam int XW  = H + 5;
    localparam int PXW = AW + 6;
    localparam int AWW = CW + 5;

    logic [2:0]    mip_reg;
    logic [ICW-1:0] count_reg;
    logic [CL-1:0] widest_reg;
    logic [CW-1:0] base_reg;
    logic          ovf_reg;
    logic [IAW-1:0] i_reg;
    logic [H-1:0]  top_reg;
    logic [CW-1:0] ia_reg;
    logic          dv_reg;
    logic [CW-1:0] dcnt_reg;
    logic [AW-1:0] daddr_reg;
    logic [CW-1:0] p_reg;
    logic [15:0]   ah_reg;
    logic          asat_reg;
    logic [IAW-1:0] oi_reg;

    logic [CW-1:0] w_reg;
    logic [CL-1:0] ch_reg;
    logic [H-1:0]  run_reg;
    logic [H-1:0]  best_reg;
    logic [AW-1:0] at_reg;
    sap_pkg::sap_out_t out_reg;

    logic [2:0]    m;
    logic [4:0]    half;
    logic [CL-1:0] cw_in;
    logic [CL-1:0] ch_in;
    logic [CW-1:0] len;
    logic          issue;
    logic          rd_done;
    logic          wr_done;
    logic [CW:0]   base2;
    logic          dbl_over;
    logic          fit;
    logic [XW-1:0] top_x;
    logic [H-1:0]  put_val;
    logic [CW-1:0] bwd_addr;

    logic [2*CL-1:0]    item_rd;
    logic [AW+H-1:0]    pos_rd;
    logic [H-1:0]       sky_rd;
    logic [2*H:0]       pre_rd;
    logic [H-1:0]       suf_rd;
    logic               sky_we;
    logic [AW-1:0]      sky_waddr;
    logic [H-1:0]       sky_wdata;
    logic [AW-1:0]      pre_raddr;
    logic [H-1:0]       pre_val;
    logic               endf;
    logic [H-1:0]       suf_val;
    logic               lastb;
    logic [H-1:0]       win_h;
    logic [PXW-1:0]     px;
    logic [XW-1:0]      py;
    logic [AWW-1:0]     aw;
    logic               sat_y;
    logic               sat_w;

    always_comb
    begin
        m        = (mip_reg > 3'(sap_pkg::MIP_MAX)) ? 3'(sap_pkg::MIP_MAX) : mip_reg;
        half     = 5'(5'd1 << m) >> 1;
        cw_in    = (CL'(in_data.tex_width) >> m) + CL'(1);
        ch_in    = (CL'(in_data.tex_height) >> m) + CL'(1);
        base2    = {base_reg, 1'b0};
        dbl_over = base2 > (CW+1)'(sap_pkg::MAX_COLUMNS);
        fit      = top_reg <= H'(base2);
        top_x    = XW'(top_reg) << m;
        put_val  = best_reg + H'(ch_reg);
        bwd_addr = base_reg - CW'(1) - ia_reg;

        case (cmd.phase)
            sap_pkg::ST_WIN: len = base_reg - w_reg + CW'(1);
            sap_pkg::ST_PUT: len = w_reg;
            default:         len = base_reg;
        endcase
        issue   = ia_reg < len;
        rd_done = dv_reg && (dcnt_reg == len - CW'(1));
        wr_done = issue && (ia_reg == len - CW'(1));

        sky_we    = issue && ((cmd.phase == sap_pkg::ST_CLEAR) ||
                              (cmd.phase == sap_pkg::ST_PUT));
        sky_waddr = (cmd.phase == sap_pkg::ST_CLEAR) ? ia_reg[AW-1:0]
                                                     : at_reg + ia_reg[AW-1:0];
        sky_wdata = (cmd.phase == sap_pkg::ST_CLEAR) ? '0 : put_val;
        pre_raddr = (cmd.phase == sap_pkg::ST_BWD) ? bwd_addr[AW-1:0]
                                                   : AW'(ia_reg + w_reg - CW'(1));

        // forward: running max from the start of each w-wide block
        pre_val = (p_reg == '0) ? sky_rd : sap_pkg::hmax(run_reg, sky_rd);
        endf    = (p_reg == w_reg - CW'(1));
        // backward: running max to the end of each block
        lastb   = pre_rd[2*H] || ({1'b0, daddr_reg} == base_reg - CW'(1));
        suf_val = lastb ? pre_rd[2*H-1:H] : sap_pkg::hmax(run_reg, pre_rd[2*H-1:H]);
        win_h   = sap_pkg::hmax(suf_rd, pre_rd[H-1:0]);

        px    = (PXW'(pos_rd[AW+H-1:H]) << m) + PXW'(half);
        py    = (XW'(pos_rd[H-1:0]) << m) + XW'(half);
        aw    = AWW'(base_reg) << m;
        sat_y = py > XW'(sap_pkg::POS_MAX);
        sat_w = aw > AWW'(sap_pkg::POS_MAX);

        status.base_done  = (widest_reg <= CL'(base_reg)) || dbl_over;
        case (cmd.phase)
            sap_pkg::ST_CLEAR, sap_pkg::ST_PUT: status.sweep_done = wr_done;
            default:                            status.sweep_done = rd_done;
        endcase
        status.items_done = ({1'b0, i_reg} == count_reg - ICW'(1));
        status.repack     = !fit && !dbl_over;
        status.ah_done    = (XW'(ah_reg) >= top_x) || (ah_reg == 16'(sap_pkg::AH_MAX));
        status.out_last   = out_reg.last_result;
        out_data          = out_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mip_reg    <= 3'(sap_pkg::MIP_MAX);
            count_reg  <= '0;
            widest_reg <= '0;
            base_reg   <= CW'(sap_pkg::MIN_COLUMNS);
            ovf_reg    <= 1'b0;
            i_reg      <= '0;
            top_reg    <= '0;
            ia_reg     <= '0;
            dv_reg     <= 1'b0;
            dcnt_reg   <= '0;
            daddr_reg  <= '0;
            p_reg      <= '0;
            ah_reg     <= 16'd1;
            asat_reg   <= 1'b0;
            oi_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mip_reg <= cfg_wdata;
            end
            if (cmd.in_fire)
            begin
                if (count_reg < ICW'(sap_pkg::MAX_ITEMS))
                begin
                    count_reg <= count_reg + ICW'(1);
                    if (cw_in > widest_reg)
                    begin
                        widest_reg <= cw_in;
                    end
                end
                if (in_data.last_item)
                begin
                    base_reg <= CW'(sap_pkg::MIN_COLUMNS);
                    ovf_reg  <= 1'b0;
                end
            end

            dcnt_reg  <= ia_reg;
            daddr_reg <= (cmd.phase == sap_pkg::ST_BWD) ? bwd_addr[AW-1:0] : ia_reg[AW-1:0];
            // sweep counter restarts with every phase change
            if (cmd.restart)
            begin
                ia_reg <= '0;
                dv_reg <= 1'b0;
            end
            else
            begin
                dv_reg <= issue;
                if (issue)
                begin
                    ia_reg <= ia_reg + CW'(1);
                end
            end

            case (cmd.phase)
                sap_pkg::ST_BASE:
                begin
                    if (widest_reg > CL'(base_reg))
                    begin
                        if (dbl_over)
                        begin
                            base_reg <= CW'(sap_pkg::MAX_COLUMNS);
                            ovf_reg  <= 1'b1;
                        end
                        else
                        begin
                            base_reg <= base2[CW-1:0];
                        end
                    end
                end
                sap_pkg::ST_LOADW:
                begin
                    if (item_rd[2*CL-1:CL] > CL'(base_reg))
                    begin
                        ovf_reg <= 1'b1;
                    end
                end
                sap_pkg::ST_FWD:
                begin
                    if (cmd.restart)
                    begin
                        p_reg <= '0;
                    end
                    else if (dv_reg)
                    begin
                        p_reg <= endf ? '0 : p_reg + CW'(1);
                    end
                end
                sap_pkg::ST_PUT:
                begin
                    if (ia_reg == '0 && put_val > top_reg)
                    begin
                        top_reg <= put_val;
                    end
                    if (wr_done)
                    begin
                        i_reg <= i_reg + IAW'(1);
                    end
                end
                sap_pkg::ST_CHECK:
                begin
                    if (!fit)
                    begin
                        if (dbl_over)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            base_reg <= base2[CW-1:0];
                        end
                    end
                end
                sap_pkg::ST_AH:
                begin
                    if (XW'(ah_reg) < top_x)
                    begin
                        if (ah_reg == 16'(sap_pkg::AH_MAX))
                        begin
                            asat_reg <= 1'b1;
                        end
                        else
                        begin
                            ah_reg <= ah_reg << 1;
                        end
                    end
                end
                sap_pkg::ST_OWAIT:
                begin
                    if (cmd.out_fire)
                    begin
                        oi_reg <= oi_reg + IAW'(1);
                    end
                end
                default:
                begin
                end
            endcase

            if (cmd.restart)
            begin
                if (cmd.next == sap_pkg::ST_CLEAR)
                begin
                    i_reg   <= '0;
                    top_reg <= '0;
                end
                if (cmd.next == sap_pkg::ST_AH)
                begin
                    ah_reg   <= 16'd1;
                    asat_reg <= 1'b0;
                end
                if (cmd.next == sap_pkg::ST_ORD && cmd.phase == sap_pkg::ST_AH)
                begin
                    oi_reg <= '0;
                end
                if (cmd.next == sap_pkg::ST_IDLE)
                begin
                    count_reg  <= '0;
                    widest_reg <= '0;
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (cmd.phase)
            sap_pkg::ST_LOADW:
            begin
                w_reg  <= (item_rd[2*CL-1:CL] > CL'(base_reg)) ? base_reg
                                                               : CW'(item_rd[2*CL-1:CL]);
                ch_reg <= item_rd[CL-1:0];
            end
            sap_pkg::ST_FWD:
            begin
                if (dv_reg)
                begin
                    run_reg <= pre_val;
                end
            end
            sap_pkg::ST_BWD:
            begin
                if (dv_reg)
                begin
                    run_reg <= suf_val;
                end
            end
            sap_pkg::ST_WIN:
            begin
                if (dv_reg && win_h < best_reg)
                begin
                    best_reg <= win_h;
                    at_reg   <= daddr_reg;
                end
            end
            sap_pkg::ST_OCAP:
            begin
                out_reg.item_index   <= 6'(oi_reg);
                out_reg.pos_x        <= (px > PXW'(sap_pkg::POS_MAX)) ? 15'(sap_pkg::POS_MAX)
                                                                     : px[14:0];
                out_reg.pos_y        <= sat_y ? 15'(sap_pkg::POS_MAX) : py[14:0];
                out_reg.atlas_width  <= sat_w ? 15'(sap_pkg::POS_MAX) : aw[14:0];
                out_reg.atlas_hgt    <= ah_reg;
                out_reg.overflow     <= ovf_reg || asat_reg || sat_w || sat_y ||
                                        (px > PXW'(sap_pkg::POS_MAX));
                out_reg.last_result  <= ({1'b0, oi_reg} == count_reg - ICW'(1));
            end
            default:
            begin
            end
        endcase
        if (cmd.restart && cmd.next == sap_pkg::ST_WIN)
        begin
            best_reg <= '1;
        end
    end

    sap_ram #(.WIDTH(2*CL), .DEPTH(sap_pkg::MAX_ITEMS)) u_item_ram (
        .clk   (clk),
        .we    (cmd.in_fire && (count_reg < ICW'(sap_pkg::MAX_ITEMS))),
        .waddr (count_reg[IAW-1:0]),
        .wdata ({cw_in, ch_in}),
        .raddr (i_reg),
        .rdata (item_rd)
    );

    sap_ram #(.WIDTH(AW+H), .DEPTH(sap_pkg::MAX_ITEMS)) u_pos_ram (
        .clk   (clk),
        .we    ((cmd.phase == sap_pkg::ST_PUT) && (ia_reg == '0)),
        .waddr (i_reg),
        .wdata ({at_reg, best_reg}),
        .raddr (oi_reg),
        .rdata (pos_rd)
    );

    sap_ram #(.WIDTH(H), .DEPTH(sap_pkg::MAX_COLUMNS)) u_sky_ram (
        .clk   (clk),
        .we    (sky_we),
        .waddr (sky_waddr),
        .wdata (sky_wdata),
        .raddr (ia_reg[AW-1:0]),
        .rdata (sky_rd)
    );

    sap_ram #(.WIDTH(2*H+1), .DEPTH(sap_pkg::MAX_COLUMNS)) u_pre_ram (
        .clk   (clk),
        .we    ((cmd.phase == sap_pkg::ST_FWD) && dv_reg),
        .waddr (daddr_reg),
        .wdata ({endf, sky_rd, pre_val}),
        .raddr (pre_raddr),
        .rdata (pre_rd)
    );

    sap_ram #(.WIDTH(H), .DEPTH(sap_pkg::MAX_COLUMNS)) u_suf_ram (
        .clk   (clk),
        .we    ((cmd.phase == sap_pkg::ST_BWD) && dv_reg),
        .waddr (daddr_reg),
        .wdata (suf_val),
        .raddr (ia_reg[AW-1:0]),
        .rdata (suf_rd)
    );

endmodule
`default_nettype wire

/* rtl/core/skyline_atlas_packer.sv */
// Top level of the skyline atlas packer: sequencer plus datapath.
// Depends on sap_pkg, sap_ctrl, sap_datapath (and sap_ram through it).
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one request per texture size.
//    Requests past 64 in a set are dropped.
//    The request with last_item set starts packing of the stored set.
//  - While packing, in_ready is low. Each pass first clears the active
//    columns (C = column count), then per item runs three skyline
//    sweeps on registered-read RAMs (forward block max, backward block max,
//    window search) and writes the item into the skyline. A height overflow
//    doubles C and repeats the pass, unless C would exceed 1024.
//  - Output channel (out_valid/out_ready/out_data): one result per stored
//    item in arrival order, the last flagged by last_result. A stalled
//    receiver simply holds the result register; nothing is lost.
//  - cfg_we/cfg_wdata set the mip level; write only while idle.
//  - Reset (rst_n low, async) empties the set, sets mip level 4, and
//    leaves the block idle and ready. Stores need no clearing after reset.
`default_nettype none
module skyline_atlas_packer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sap_pkg::sap_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sap_pkg::sap_out_t      out_data
);

    sap_pkg::sap_cmd_t    cmd;
    sap_pkg::sap_status_t status;

    // sequencer: owns the handshakes and the phase
    sap_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.last_item),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // all storage and arithmetic
    sap_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

    // never collecting and presenting at once
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output active together");

    // last request of a set starts packing
    a_pack: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.last_item) |=> !in_ready)
        else $error("packing did not start");

    // final result returns the block to collecting
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.last_result) |=> in_ready)
        else $error("block not idle after last result");

    // a placement lies inside the atlas
    a_xin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.pos_x < out_data.atlas_width))
        else $error("pos_x outside atlas");

endmodule
`default_nettype wire

/* verif/skyline_atlas_packer_check.sv */
// Result checker for the skyline atlas packer: watches the request and result channels,
// predicts placements per set and compares them. Depends on sap_pkg.
module skyline_atlas_packer_check (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_wdata,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire sap_pkg::sap_in_t  in_data,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire sap_pkg::sap_out_t out_data,
    output int                     fail_count,
    output int                     pending,
    output int                     result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [2:0] mip_reg;
    int unsigned cell_w [sap_pkg::MAX_ITEMS];
    int unsigned cell_h [sap_pkg::MAX_ITEMS];
    int unsigned place_x [sap_pkg::MAX_ITEMS];
    int unsigned place_y [sap_pkg::MAX_ITEMS];
    int unsigned sky [sap_pkg::MAX_COLUMNS];
    int unsigned stored;
    sap_pkg::sap_out_t placements [$];

    function automatic int unsigned pow2_ceil(int unsigned x);
        int unsigned p;
        p = 1;
        while (p < x && p < 32'h8000_0000) p = p << 1;
        return p;
    endfunction

    // Runs the skyline passes; returns column-limit flag, sets cols and rows.
    function automatic bit pack_set(output int unsigned cols, output int unsigned rows);
        int unsigned widest, base, top, w, best, at, hh;
        bit lim;
        widest = 0;
        lim = 0;
        base = sap_pkg::MIN_COLUMNS;
        for (int i = 0; i < stored; i++)
            if (cell_w[i] > widest) widest = cell_w[i];
        if (widest > base) begin
            if (pow2_ceil(widest) > sap_pkg::MAX_COLUMNS) begin
                base = sap_pkg::MAX_COLUMNS;
                lim = 1;
            end
            else base = pow2_ceil(widest);
        end
        forever
        begin
            top = 0;
            for (int c = 0; c < sap_pkg::MAX_COLUMNS; c++) sky[c] = 0;
            for (int i = 0; i < stored; i++)
            begin
                w = cell_w[i];
                best = 32'h7FFF_FFFF;
                at = 0;
                if (w > base)
                begin
                    w = base;
                    lim = 1;
                end
                for (int j = 0; j + w <= base; j++)
                begin
                    hh = 0;
                    for (int k = 0; k < w; k++)
                        if (sky[j+k] > hh) hh = sky[j+k];
                    if (hh < best)
                    begin
                        best = hh;
                        at = j;
                    end
                end
                for (int k = 0; k < w; k++) sky[at+k] = best + cell_h[i];
                place_x[i] = at;
                place_y[i] = best;
                if (best + cell_h[i] > top) top = best + cell_h[i];
            end
            rows = top;
            cols = base;
            if (top <= base * 2) break;
            if (base * 2 > sap_pkg::MAX_COLUMNS)
            begin
                lim = 1;
                break;
            end
            base = base * 2;
        end
        return lim;
    endfunction

    task automatic take_texture(sap_pkg::sap_in_t req);
        int unsigned m, cols, rows, border, aw, ah, px, py;
        bit lim, asat, sat;
        sap_pkg::sap_out_t r;
        m = (mip_reg > sap_pkg::MIP_MAX) ? sap_pkg::MIP_MAX : mip_reg;
        if (stored < sap_pkg::MAX_ITEMS)
        begin
            cell_w[stored] = (req.tex_width >> m) + 1;
            cell_h[stored] = (req.tex_height >> m) + 1;
            stored++;
        end
        if (!req.last_item) return;
        lim = pack_set(cols, rows);
        border = 1 << m;
        asat = 0;
        aw = cols * border;
        if (aw > sap_pkg::POS_MAX)
        begin
            aw = sap_pkg::POS_MAX;
            asat = 1;
        end
        ah = pow2_ceil(rows * border);
        if (ah > sap_pkg::AH_MAX)
        begin
            ah = sap_pkg::AH_MAX;
            asat = 1;
        end
        for (int i = 0; i < stored; i++)
        begin
            sat = asat;
            px = place_x[i] * border + border / 2;
            py = place_y[i] * border + border / 2;
            if (px > sap_pkg::POS_MAX)
            begin
                px = sap_pkg::POS_MAX;
                sat = 1;
            end
            if (py > sap_pkg::POS_MAX)
            begin
                py = sap_pkg::POS_MAX;
                sat = 1;
            end
            r.item_index = i[5:0];
            r.pos_x = px[14:0];
            r.pos_y = py[14:0];
            r.atlas_width = aw[14:0];
            r.atlas_hgt = ah[15:0];
            r.overflow = lim | sat;
            r.last_result = (i + 1 == stored);
            placements = {placements, r};
        end
        stored = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mip_reg = 3'd4;
            stored = 0;
            placements.delete();
            fail_count = 0;
            result_count = 0;
        end
        else
        begin
            if (cfg_we) mip_reg = cfg_wdata;
            if (out_valid && out_ready)
            begin
                result_count++;
                if (placements.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %p", out_data);
                end
                else
                begin
                    if (out_data !== placements[0])
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch exp %p got %p", placements[0], out_data);
                    end
                    void'(placements.pop_front());
                end
            end
            if (in_valid && in_ready) take_texture(in_data);
        end
        pending = placements.size();
    end
endmodule

/* verif/skyline_atlas_packer_test.sv */
// Testbench top for skyline_atlas_packer: clock, reset, stimulus and verdict.
// Depends on sap_pkg, the packer RTL and skyline_atlas_packer_check.
module skyline_atlas_packer_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk, rst_n, cfg_we, in_valid, out_ready;
    logic [2:0] cfg_wdata;
    logic in_ready, out_valid;
    sap_pkg::sap_in_t in_data;
    sap_pkg::sap_out_t out_data;
    int fail_count, pending, result_count;
    int sent;
    bit calm;       // last stretch of the run: no idling on either side
    bit hold_go;    // starts the long receiver stall
    bit hold_off;   // long receiver stall to back the block up

    skyline_atlas_packer u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    skyline_atlas_packer_check u_check (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending), .result_count(result_count)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off) out_ready <= 0;
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_ready <= 1;
            end
            else out_ready <= 1;
        end
    end

    // Long receiver stall, counted here; spans packing of a full set so
    // results back up and the sender sits on a pending request.
    initial
    begin
        hold_off = 0;
        wait (hold_go);
        hold_off = 1;
        repeat (40000) @(posedge clk);
        hold_off = 0;
    end

    // Sends one texture request; optionally idles for a random burst first.
    task automatic send_texture(int unsigned w, int unsigned h, bit last);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1;
        in_data.tex_width <= w[14:0];
        in_data.tex_height <= h[14:0];
        in_data.last_item <= last;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    // Writes the mip level once everything in flight has drained.
    task automatic set_mip(logic [2:0] v);
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // A set of n textures; mostly small sizes, occasionally huge.
    task automatic random_set(int n);
        int unsigned w, h;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0: w = $urandom_range(1, 16384);
                1: w = 32767 - $urandom_range(0, 15);
                default: w = $urandom_range(1, 300);
            endcase
            case ($urandom_range(0, 9))
                0: h = $urandom_range(1, 16384);
                1: h = $urandom_range(0, 32767);
                default: h = $urandom_range(1, 300);
            endcase
            send_texture(w, h, i == n - 1);
        end
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        in_valid = 0;
        in_data = '0;
        calm = 0;
        hold_go = 0;
        sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: single smallest item, extremes, non-last items.
        send_texture(1, 1, 1);
        send_texture(16384, 1, 0);
        send_texture(1, 16384, 1);
        send_texture(32767, 32767, 1);
        send_texture(0, 0, 1);
        set_mip(3'd0);
        // Wide item beyond the column limit, and tall stack forcing doubling.
        send_texture(5000, 3, 1);
        send_texture(3, 3, 0);
        send_texture(3, 900, 0);
        send_texture(3, 900, 1);
        set_mip(3'd7);   // above the max, saturates to 4
        send_texture(100, 100, 1);
        // Cell size is taken at arrival: change mip mid-set is not allowed,
        // so cover pixel output at a different level only between sets.
        set_mip(3'd2);
        random_set(3);

        // Store-full: 70 items, only 64 kept; last one dropped still packs.
        // The receiver holds off meanwhile and the next set keeps offering.
        set_mip(3'd2);
        hold_go = 1;
        for (int i = 0; i < 70; i++)
            send_texture($urandom_range(1, 64), $urandom_range(1, 64), i == 69);
        random_set(4);

        while (sent < 430)
        begin
            set_mip(3'($urandom_range(0, 7)));
            random_set($urandom_range(1, 20));
        end
        calm = 1;
        set_mip(3'd1);
        random_set(30);
        set_mip(3'd4);
        random_set(20);

        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        $display("sent %0d texture requests over all mip levels, store-full and a long stall",
                 sent);
        $display("checked %0d placements", result_count);
        if (fail_count == 0)
            $display("skyline_atlas_packer verification clean");
        else
            $display("skyline_atlas_packer verification failed");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("skyline_atlas_packer verification failed");
        $finish;
    end
endmodule

/* files.f */
rtl/core/sap_pkg.sv
rtl/core/sap_ram.sv
rtl/core/sap_ctrl.sv
rtl/core/sap_datapath.sv
rtl/core/skyline_atlas_packer.sv
verif/skyline_atlas_packer_check.sv
verif/skyline_atlas_packer_test.sv
